FILE: src/crc16ce_pkg.sv
// Shared types, constants and helper functions for the configurable CRC-16 engine.
`timescale 1ns / 1ps

package crc16ce_pkg;

    localparam int CRC_W  = 16;
    localparam int BYTE_W = 8;
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [BYTE_W-1:0] t_byte;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_POLYNOMIAL      = 2'd0,
        REG_INITIAL_VALUE   = 2'd1,
        REG_SHIFT_RIGHT     = 2'd2,
        REG_INVERT_AND_SWAP = 2'd3
    } t_reg_idx;

    // Reset values of the configuration registers
    localparam t_crc RST_POLYNOMIAL      = 16'h8005;
    localparam t_crc RST_INITIAL_VALUE   = 16'hFFFF;
    localparam logic RST_SHIFT_RIGHT     = 1'b1;
    localparam logic RST_INVERT_AND_SWAP = 1'b0;

    // Settings that steer the byte fold
    typedef struct packed {
        t_crc polynomial;
        logic shift_right;
    } t_fold_cfg;

    // Bit reversal of a 16-bit word
    function automatic t_crc mirror16(input t_crc v);
        t_crc r;
        r = '0;
        for (int k = 0; k < CRC_W; k++) begin
            r[CRC_W-1-k] = v[k];
        end
        return r;
    endfunction

endpackage

FILE: src/crc16ce_fold.sv
// Folds one message byte into a 16-bit CRC: eight unrolled XOR-shift steps.
`timescale 1ns / 1ps

module crc16ce_fold (
    input  crc16ce_pkg::t_fold_cfg i_cfg,
    input  crc16ce_pkg::t_crc      i_crc,
    input  crc16ce_pkg::t_byte     i_byte,
    output crc16ce_pkg::t_crc      o_crc
);
    import crc16ce_pkg::*;

    t_crc poly_rev;
    t_crc crc_lsb;
    t_crc crc_msb;

    assign poly_rev = mirror16(i_cfg.polynomial);

    // Reflected form: byte into low bits, shift right
    always_comb begin
        crc_lsb = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < BYTE_W; k++) begin
            crc_lsb = crc_lsb[0] ? ((crc_lsb >> 1) ^ poly_rev) : (crc_lsb >> 1);
        end
    end

    // Normal form: byte into high bits, shift left
    always_comb begin
        crc_msb = i_crc ^ {i_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            crc_msb = crc_msb[CRC_W-1] ? ((crc_msb << 1) ^ i_cfg.polynomial)
                                       : (crc_msb << 1);
        end
    end

    assign o_crc = i_cfg.shift_right ? crc_lsb : crc_msb;

endmodule

FILE: src/crc16_configurable_engine.sv
// Top level of the configurable CRC-16 engine: APB registers, stream ports, CRC state.
`timescale 1ns / 1ps

// Configurable CRC-16 over a byte stream. One byte is taken per transfer on the
// slave stream, a byte per clock unless the output stalls; tlast marks the final byte
// of a message. The eight-step XOR-shift network that feeds the running CRC register
// sets that figure: each byte is folded in the cycle it is accepted. The CRC of a
// message appears on the master stream the cycle after its last byte is accepted,
// held in an output register, and the running CRC reloads the initial value so the
// next message can start at once. Registers (APB, byte address 4*i): 0 polynomial in
// normal form without x^16, 1 initial value (writing it also restarts the running
// CRC), 2 shift_right (1 = reflected, LSB first with mirrored polynomial), 3
// invert_and_swap (1 = complement and byte-swap the result, DNP3 form). Change
// configuration only while no message is in flight.

module crc16_configurable_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crc16ce_pkg::APB_AW-1:0]  paddr,
    input  logic [crc16ce_pkg::APB_DW-1:0]  pwdata,
    output logic [crc16ce_pkg::APB_DW-1:0]  prdata,
    output logic                            pready,
    // Byte stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,  // last_byte
    // CRC stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata   // [15:0] crc_result
);
    import crc16ce_pkg::*;

    t_crc      r_polynomial;
    t_crc      r_initial_value;
    logic      r_shift_right;
    logic      r_invert_and_swap;
    t_crc      r_crc;
    t_crc      r_out;
    logic      r_out_valid;

    t_crc      n_crc;
    t_crc      n_out;
    t_crc      fold_crc;
    t_crc      crc_inv;
    t_fold_cfg fold_cfg;
    t_reg_idx  reg_idx;
    logic      cfg_wr;
    logic      in_xfer;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    // Register read mux
    always_comb begin
        case (reg_idx)
            REG_POLYNOMIAL:      prdata = {{(APB_DW-CRC_W){1'b0}}, r_polynomial};
            REG_INITIAL_VALUE:   prdata = {{(APB_DW-CRC_W){1'b0}}, r_initial_value};
            REG_SHIFT_RIGHT:     prdata = {{(APB_DW-1){1'b0}}, r_shift_right};
            REG_INVERT_AND_SWAP: prdata = {{(APB_DW-1){1'b0}}, r_invert_and_swap};
            default:             prdata = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polynomial      <= RST_POLYNOMIAL;
            r_initial_value   <= RST_INITIAL_VALUE;
            r_shift_right     <= RST_SHIFT_RIGHT;
            r_invert_and_swap <= RST_INVERT_AND_SWAP;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_POLYNOMIAL:      r_polynomial      <= pwdata[CRC_W-1:0];
                REG_INITIAL_VALUE:   r_initial_value   <= pwdata[CRC_W-1:0];
                REG_SHIFT_RIGHT:     r_shift_right     <= pwdata[0];
                REG_INVERT_AND_SWAP: r_invert_and_swap <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Byte fold
    assign fold_cfg = '{polynomial: r_polynomial, shift_right: r_shift_right};

    crc16ce_fold u_fold (
        .i_cfg  (fold_cfg),
        .i_crc  (r_crc),
        .i_byte (s_axis_tdata),
        .o_crc  (fold_crc)
    );

    // Input accepted whenever the output register is empty or draining
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;

    // Final CRC form
    assign crc_inv = ~fold_crc;
    assign n_out   = r_invert_and_swap ? {crc_inv[BYTE_W-1:0], crc_inv[CRC_W-1:BYTE_W]}
                                       : fold_crc;

    // Next running CRC
    always_comb begin
        n_crc = r_crc;
        if (cfg_wr && reg_idx == REG_INITIAL_VALUE) begin
            n_crc = pwdata[CRC_W-1:0];
        end else if (in_xfer) begin
            n_crc = s_axis_tlast ? r_initial_value : fold_crc;
        end
    end

    // Running CRC and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= RST_INITIAL_VALUE;
            r_out_valid <= 1'b0;
        end else begin
            r_crc <= n_crc;
            if (in_xfer && s_axis_tlast) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
